/* hdl/lus_pkg.sv */
// Package for the longest unique substring unit.
// Holds the widths, limits and shared types; no dependencies.
package lus_pkg;

    localparam int CODE_W   = 8;
    localparam int POS_W    = 16;
    localparam int LEN_W    = 9;
    localparam int ALPHABET = 256;
    localparam int TABLE_AW = $clog2(ALPHABET);

    localparam logic [POS_W-1:0]  MAX_POS  = POS_W'(65535);
    localparam logic [CODE_W-1:0] TOP_CODE = CODE_W'(ALPHABET - 1);
    localparam logic [LEN_W-1:0]  MAX_LEN  = LEN_W'(ALPHABET);

    typedef logic [POS_W-1:0]    pos_t;
    typedef logic [LEN_W-1:0]    len_t;
    typedef logic [TABLE_AW-1:0] tab_addr_t;

    // Item held in the compute stage, waiting for its table read.
    typedef struct packed {
        tab_addr_t code;
        logic      first;
        logic      fwd_hit;
        pos_t      fwd_pos;
    } stage_item_t;

    // Codes beyond the alphabet fold onto its top code.
    function automatic tab_addr_t fold_code(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] c;
        c = (code > TOP_CODE) ? TOP_CODE : code;
        return TABLE_AW'(c);
    endfunction

endpackage

/* hdl/lus_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// A read at the address being written returns the old contents. No dependencies.
module lus_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/longest_unique_substring_unit.sv */
// Top level of the longest unique substring unit.
// Depends on lus_pkg and on lus_ram for the last-seen position table.
//
// Usage
// -----
// The slave channel takes one character per item: s_tdata carries the byte
// and s_tuser flags the first character of a new string, which forgets all
// history (table entries, window start, position, best length, overflow).
// For every item the master channel returns one item with the length of the
// repeat-free window ending at that character, the best such length in the
// current string and a sticky overflow flag, set once the string grows past
// the range of the 16-bit position counter (the position then saturates).
//
// An accepted item enters the compute stage; its result is registered, with
// m_tvalid, in the output register as the item leaves that stage. One item
// per cycle is sustained while the receiver does not stall: the table lookup
// is issued on acceptance, the update is written back as the item leaves,
// and an equal character directly behind comes from a forwarding register.
//
// When the receiver stalls, the result waits in the output register and the
// item behind it waits in the compute stage; s_tready drops only while both
// are occupied. A synchronous low on aresetn empties the pipeline and clears
// the valid bits and counters at once, so no clearing pass is needed.
module longest_unique_substring_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // Slave channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tuser,   // [0] first_char
    // Master channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [8:0] window_len, [17:9] best_len, [18] overflow
);

    // Pipeline control.
    logic                  s1_valid_reg;
    lus_pkg::stage_item_t  s1_item_reg;
    logic                  s1_advance;
    logic                  in_accept;
    lus_pkg::tab_addr_t    in_code;

    // Per-string state.
    logic [lus_pkg::ALPHABET-1:0] valid_reg, valid_next;
    lus_pkg::pos_t position_reg, position_next;
    lus_pkg::pos_t wstart_reg, wstart_next;
    lus_pkg::len_t best_reg, best_next;
    logic          ovf_reg, ovf_next;

    // Output register.
    logic          m_valid_reg;
    lus_pkg::len_t m_win_reg;
    lus_pkg::len_t m_best_reg;
    logic          m_ovf_reg;

    // Compute stage signals.
    lus_pkg::pos_t ram_q;
    lus_pkg::pos_t pos_in, wstart_in, here, last_pos;
    lus_pkg::len_t best_in, win_len;
    logic          ovf_in, sat, seen, hit;
    logic [lus_pkg::POS_W:0] wstart_cand, span;

    assign in_code    = lus_pkg::fold_code(s_tdata);
    assign s1_advance = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready   = !s1_valid_reg || s1_advance;
    assign in_accept  = s_tvalid && s_tready;

    // Last-seen position table: read on acceptance, written when the item
    // leaves the compute stage.
    lus_ram #(
        .WIDTH (lus_pkg::POS_W),
        .DEPTH (lus_pkg::ALPHABET)
    ) u_last_pos (
        .aclk  (aclk),
        .we    (s1_advance),
        .waddr (s1_item_reg.code),
        .wdata (here),
        .re    (in_accept),
        .raddr (in_code),
        .rdata (ram_q)
    );

    always_comb begin
        // A string start works from cleared state.
        pos_in    = s1_item_reg.first ? '0 : position_reg;
        wstart_in = s1_item_reg.first ? '0 : wstart_reg;
        best_in   = s1_item_reg.first ? '0 : best_reg;
        ovf_in    = s1_item_reg.first ? 1'b0 : ovf_reg;

        sat  = (pos_in >= lus_pkg::MAX_POS);
        here = sat ? lus_pkg::MAX_POS : pos_in;

        // The memory read missed a write made at the same edge; take the
        // forwarded position in that case.
        last_pos = s1_item_reg.fwd_hit ? s1_item_reg.fwd_pos : ram_q;
        seen     = !s1_item_reg.first && valid_reg[s1_item_reg.code];
        hit      = seen && (last_pos >= wstart_in);

        wstart_cand = hit ? ({1'b0, last_pos} + 1'b1) : {1'b0, wstart_in};
        wstart_next = (wstart_cand > {1'b0, here}) ? here
                                                   : wstart_cand[lus_pkg::POS_W-1:0];

        span    = {1'b0, here} - {1'b0, wstart_next} + 1'b1;
        win_len = (span > (lus_pkg::POS_W+1)'(lus_pkg::ALPHABET))
                  ? lus_pkg::MAX_LEN : span[lus_pkg::LEN_W-1:0];

        best_next     = (win_len > best_in) ? win_len : best_in;
        ovf_next      = ovf_in || sat;
        position_next = sat ? here : here + 1'b1;

        valid_next = s1_item_reg.first ? '0 : valid_reg;
        valid_next[s1_item_reg.code] = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            valid_reg    <= '0;
            position_reg <= '0;
            wstart_reg   <= '0;
            best_reg     <= '0;
            ovf_reg      <= 1'b0;
        end else begin
            if (in_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_advance) begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_advance) begin
                m_valid_reg  <= 1'b1;
                valid_reg    <= valid_next;
                position_reg <= position_next;
                wstart_reg   <= wstart_next;
                best_reg     <= best_next;
                ovf_reg      <= ovf_next;
            end else if (m_tready) begin
                m_valid_reg  <= 1'b0;
            end
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_item_reg.code    <= in_code;
            s1_item_reg.first   <= s_tuser;
            s1_item_reg.fwd_hit <= s1_advance && (s1_item_reg.code == in_code);
            s1_item_reg.fwd_pos <= here;
        end
        if (s1_advance) begin
            m_win_reg  <= win_len;
            m_best_reg <= best_next;
            m_ovf_reg  <= ovf_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_ovf_reg, m_best_reg, m_win_reg};

endmodule

/* tb/sv/lus_window_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the longest unique substring unit: watches both channels,
// predicts each result from the accepted characters and compares it.
// Depends on lus_pkg for the widths and limits.
module lus_window_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] char_code
    input  logic              s_tuser,   // [0] first_char
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [23:0]       m_tdata,   // [8:0] window_len, [17:9] best_len, [18] overflow
    output int unsigned       outstanding,
    output int unsigned       fails
);

    typedef struct packed {
        logic          overflow;
        lus_pkg::len_t best_len;
        lus_pkg::len_t window_len;
    } window_result_t;

    // Predicted window state of the current string.
    lus_pkg::pos_t                last_seen [lus_pkg::ALPHABET];
    logic [lus_pkg::ALPHABET-1:0] seen;
    lus_pkg::pos_t                win_start;
    lus_pkg::pos_t                next_pos;
    lus_pkg::len_t                best;
    logic                         ovf;

    window_result_t      window_q [$];

    initial begin
        outstanding = 0;
        fails       = 0;
    end

    function automatic window_result_t advance_window(
        input logic [lus_pkg::CODE_W-1:0] raw,
        input logic first
    );
        lus_pkg::tab_addr_t      idx;
        logic [lus_pkg::POS_W:0] start_n;
        logic [lus_pkg::POS_W:0] span;
        lus_pkg::pos_t           here;
        lus_pkg::len_t           win;
        if (first) begin
            seen      = '0;
            win_start = '0;
            next_pos  = '0;
            best      = '0;
            ovf       = 1'b0;
        end
        idx = (int'(raw) >= lus_pkg::ALPHABET) ? lus_pkg::tab_addr_t'(lus_pkg::ALPHABET - 1)
                                               : lus_pkg::tab_addr_t'(raw);
        if (next_pos >= lus_pkg::MAX_POS) begin
            next_pos = lus_pkg::MAX_POS;
            ovf      = 1'b1;
        end
        here    = next_pos;
        start_n = {1'b0, win_start};
        if (seen[idx] && last_seen[idx] >= win_start) begin
            start_n = {1'b0, last_seen[idx]} + 1'b1;
        end
        // Once the position has saturated the start must not run past it.
        if (start_n > {1'b0, here}) begin
            start_n = {1'b0, here};
        end
        win_start      = start_n[lus_pkg::POS_W-1:0];
        last_seen[idx] = here;
        seen[idx]      = 1'b1;
        span = {1'b0, here} - start_n + 1'b1;
        win  = (span > lus_pkg::ALPHABET) ? lus_pkg::MAX_LEN : lus_pkg::len_t'(span);
        if (win > best) begin
            best = win;
        end
        if (next_pos < lus_pkg::MAX_POS) begin
            next_pos = next_pos + 1'b1;
        end
        return '{overflow: ovf, best_len: best, window_len: win};
    endfunction

    function automatic void note_mismatch(input string field, input int unsigned want,
                                          input int unsigned got);
        fails = fails + 1;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    always @(posedge aclk) begin : watch
        window_result_t got;
        window_result_t want;
        if (!aresetn) begin
            seen      = '0;
            win_start = '0;
            next_pos  = '0;
            best      = '0;
            ovf       = 1'b0;
            window_q.delete();
            outstanding <= 0;
        end else begin
            // Results are retired before new characters are predicted, so an
            // unexpected result can never consume a prediction of this edge.
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(window_result_t)-1:0];
                if (window_q.size() == 0) begin
                    fails = fails + 1;
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_tdata);
                end else begin
                    want = window_q.pop_front();
                    if (got.window_len != want.window_len) begin
                        note_mismatch("window_len", 32'(want.window_len),
                                      32'(got.window_len));
                    end
                    if (got.best_len != want.best_len) begin
                        note_mismatch("best_len", 32'(want.best_len), 32'(got.best_len));
                    end
                    if (got.overflow != want.overflow) begin
                        note_mismatch("overflow", 32'(want.overflow), 32'(got.overflow));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                window_q.push_back(advance_window(s_tdata, s_tuser));
            end
            outstanding <= unsigned'(window_q.size());
        end
    end

endmodule

/* tb/sv/longest_unique_substring_unit_tb.sv */
`timescale 1ns / 100ps
// Top of the testbench for the longest unique substring unit: clock, reset,
// character stimulus, receiver back-pressure and the verdict.
// Depends on lus_pkg, the unit itself and lus_window_checker.
module longest_unique_substring_unit_tb;

    // A stall of the receiver long enough to fill the two-stage pipeline and
    // hold the slave channel off for a good while.
    localparam int unsigned RX_HOLD_CYCLES = 300;
    // Items per randomised phase; four phases plus the directed opening.
    localparam int unsigned PHASE_ITEMS    = 360;
    // Cycles allowed after the last result, before the verdict.
    localparam int unsigned DRAIN_CYCLES   = 10;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] char_code
    logic        s_tuser  = 1'b0;    // [0] first_char
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;            // [8:0] window_len, [17:9] best_len, [18] overflow

    int unsigned outstanding;
    int unsigned fails;

    // Percentages of cycles in which the sender idles or the receiver stalls.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    logic        rx_hold = 1'b0;
    event        rx_hold_req;

    // 10 ns clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    longest_unique_substring_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    lus_window_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .outstanding (outstanding),
        .fails       (fails)
    );

    // The long receiver hold-off is counted here, apart from the stimulus, so
    // that the sender keeps offering items while the output is blocked.
    always begin
        @(rx_hold_req);
        rx_hold <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    // Receiver: random stalls at the rate of the current phase, or a solid
    // stall while a hold-off is running.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_hold) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offers one character, after a random number of idle cycles, and returns
    // at the edge where it is accepted. tvalid is left high so that items can
    // follow back to back.
    task automatic send_char(input logic [7:0] code, input logic first);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        s_tuser  <= first;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Stops offering and waits until every predicted result has arrived. The
    // first edge lets the count take in the item accepted last.
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // Randomised strings. Most are well formed: a flagged first character
    // followed by content drawn from a narrow band of codes (many repeats),
    // from the whole byte range, or a full permutation of the alphabet that
    // opens the window to its maximum. The rest is noise with the start flag
    // set at random.
    task automatic random_phase(input int unsigned n_items);
        int unsigned sent;
        int unsigned kind;
        int unsigned len;
        int unsigned base;
        int unsigned span;
        int unsigned i;
        int unsigned j;
        int          tmp;
        int          perm [lus_pkg::ALPHABET];
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(99);
            if (kind < 40) begin
                len  = $urandom_range(40, 1);
                base = $urandom_range(255);
                span = $urandom_range(8, 2);
                for (i = 0; i < len; i++) begin
                    send_char(8'(base + $urandom_range(span - 1)), i == 0);
                end
            end else if (kind < 70) begin
                len = $urandom_range(60, 1);
                for (i = 0; i < len; i++) begin
                    send_char(8'($urandom_range(255)), i == 0);
                end
            end else if (kind < 85) begin
                for (i = 0; i < lus_pkg::ALPHABET; i++) begin
                    perm[i] = int'(i);
                end
                for (i = lus_pkg::ALPHABET - 1; i > 0; i--) begin
                    j       = $urandom_range(i);
                    tmp     = perm[i];
                    perm[i] = perm[j];
                    perm[j] = tmp;
                end
                for (i = 0; i < lus_pkg::ALPHABET; i++) begin
                    send_char(8'(perm[i]), i == 0);
                end
                // Repeats after a full window pull the start forward again.
                len = $urandom_range(20, 1);
                for (i = 0; i < len; i++) begin
                    send_char(8'($urandom_range(255)), 1'b0);
                end
                len = len + lus_pkg::ALPHABET;
            end else begin
                len = $urandom_range(10, 1);
                for (i = 0; i < len; i++) begin
                    send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
                end
            end
            sent = sent + len;
        end
    endtask

    // Run limit, far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed opening. The very first item carries no start flag: the
        // string still begins here, straight after reset.
        send_char(8'h61, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h61, 1'b0);    // repeat inside the window
        send_char(8'hFF, 1'b0);
        send_char(8'hFF, 1'b0);    // equal characters back to back
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b0);
        // A flagged start forgets everything, including the codes just seen.
        send_char(8'hFF, 1'b1);
        send_char(8'h61, 1'b0);
        send_char(8'h00, 1'b0);
        // Start flags on consecutive items.
        send_char(8'h10, 1'b1);
        send_char(8'h10, 1'b1);
        // Repeats whose earlier occurrence lies at or after the window start
        // pull the start forward.
        send_char(8'h20, 1'b0);
        send_char(8'h10, 1'b0);
        send_char(8'h20, 1'b0);
        send_char(8'h30, 1'b0);
        send_char(8'h10, 1'b0);
        send_char(8'h7F, 1'b0);
        send_char(8'h80, 1'b0);
        send_char(8'h55, 1'b0);
        send_char(8'hAA, 1'b0);
        send_char(8'h55, 1'b0);
        drain();

        // No idling; a long receiver hold-off lets the pipeline fill up and
        // stall the sender while it keeps offering characters.
        -> rx_hold_req;
        random_phase(PHASE_ITEMS);
        drain();

        send_idle_pct = 75;
        recv_stall_pct = 0;
        random_phase(PHASE_ITEMS);
        drain();

        send_idle_pct = 0;
        recv_stall_pct = 75;
        random_phase(PHASE_ITEMS);
        drain();

        send_idle_pct = 38;
        recv_stall_pct = 38;
        random_phase(PHASE_ITEMS);
        drain();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fails == 0 && outstanding == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
